>>> rtl/six_step_commutation_sequencer_macros.svh
// Assertion macros shared by the commutation sequencer modules.
`ifndef SIX_STEP_COMMUTATION_SEQUENCER_MACROS_SVH
`define SIX_STEP_COMMUTATION_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sscs check failed");

// Next-cycle implication, checked outside reset.
`define SSCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sscs check failed");

`endif

>>> rtl/sscs_pkg.sv
// Shared types, constants and step tables of the commutation sequencer.
package sscs_pkg;

  localparam int TIME_BITS_DEF = 10;
  localparam int ON_W          = 10;
  localparam int OFF_W         = 8;
  localparam int ATT_W         = 8;
  localparam int PIN_W         = 3;
  localparam int STEP_W        = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;

  localparam logic [STEP_W-1:0] STEPS = 3'd6;

  localparam logic [ON_W-1:0]  ON_TICKS_RST     = 10'd400;
  localparam logic [OFF_W-1:0] OFF_TICKS_RST    = 8'd100;
  localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_TICKS     = 2'd0,
    REG_OFF_TICKS    = 2'd1,
    REG_MAX_ATTEMPTS = 2'd2,
    REG_REVERSE_DIR  = 2'd3
  } sscs_reg_t;

  typedef struct packed {
    logic [ON_W-1:0]  on_ticks;
    logic [OFF_W-1:0] off_ticks;
    logic [ATT_W-1:0] max_attempts;
    logic             reverse_dir;
  } sscs_cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0]  drive_pins;
    logic [STEP_W-1:0] step_index;
    logic              driving;
    logic              advanced;
  } sscs_result_t;

  // Drive pattern (and expected sense pattern) of a step.
  function automatic logic [PIN_W-1:0] step_pattern(input logic rev,
                                                    input logic [STEP_W-1:0] step);
    logic [PIN_W-1:0] pat;
    pat = '0;
    if (!rev) begin
      case (step)
        3'd0:    pat = 3'd4;
        3'd1:    pat = 3'd6;
        3'd2:    pat = 3'd2;
        3'd3:    pat = 3'd3;
        3'd4:    pat = 3'd1;
        3'd5:    pat = 3'd5;
        default: pat = 3'd4;
      endcase
    end else begin
      case (step)
        3'd0:    pat = 3'd1;
        3'd1:    pat = 3'd3;
        3'd2:    pat = 3'd2;
        3'd3:    pat = 3'd6;
        3'd4:    pat = 3'd4;
        3'd5:    pat = 3'd5;
        default: pat = 3'd1;
      endcase
    end
    return pat;
  endfunction

endpackage

>>> rtl/sscs_ctrl.sv
// Commutation state: step, drive/off phase, tick and attempt counters.
module sscs_ctrl #(
  parameter int TIME_BITS = sscs_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [sscs_pkg::PIN_W-1:0]   sense_pins,
  input  sscs_pkg::sscs_cfg_t          cfg,
  output sscs_pkg::sscs_result_t       result
);
  import sscs_pkg::*;

  localparam int CW = (TIME_BITS > ON_W) ? TIME_BITS : ON_W;

  logic [STEP_W-1:0]    step_reg, step_reg_next;
  logic                 phase_on, phase_on_next;
  logic [TIME_BITS-1:0] tick_count, tick_count_next;
  logic [ATT_W-1:0]     attempt_count, attempt_count_next;

  logic [STEP_W-1:0]    step_cur;
  logic [PIN_W-1:0]     pat;
  logic [CW-1:0]        on_ext;
  logic [CW-1:0]        time_max_ext;
  logic [TIME_BITS-1:0] on_lim;
  logic [TIME_BITS-1:0] off_lim;
  logic [ATT_W-1:0]     att_lim;
  logic [TIME_BITS-1:0] tick_inc;
  logic [ATT_W-1:0]     attempt_inc;
  logic                 adv;

  always_comb begin
    step_cur     = (step_reg < STEPS) ? step_reg : '0;
    pat          = step_pattern(cfg.reverse_dir, step_cur);
    on_ext       = (cfg.on_ticks == '0) ? CW'(1) : CW'(cfg.on_ticks);
    time_max_ext = CW'({TIME_BITS{1'b1}});
    on_lim       = (on_ext > time_max_ext) ? {TIME_BITS{1'b1}} : on_ext[TIME_BITS-1:0];
    off_lim      = (cfg.off_ticks == '0) ? TIME_BITS'(1) : TIME_BITS'(cfg.off_ticks);
    att_lim      = (cfg.max_attempts == '0) ? ATT_W'(1) : cfg.max_attempts;
    tick_inc     = tick_count + TIME_BITS'(1);
    attempt_inc  = attempt_count + ATT_W'(1);

    adv                = 1'b0;
    phase_on_next      = phase_on;
    tick_count_next    = tick_count;
    attempt_count_next = attempt_count;

    if (phase_on) begin
      tick_count_next = tick_inc;
      if (tick_inc >= on_lim) begin
        phase_on_next   = 1'b0;
        tick_count_next = '0;
      end
    end else if (sense_pins == pat) begin
      adv = 1'b1;
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= off_lim) begin
        attempt_count_next = attempt_inc;
        if (attempt_inc >= att_lim) begin
          adv = 1'b1;
        end else begin
          phase_on_next   = 1'b1;
          tick_count_next = '0;
        end
      end
    end

    step_reg_next = step_cur;
    if (adv) begin
      step_reg_next      = (step_cur + STEP_W'(1) >= STEPS) ? '0 : step_cur + STEP_W'(1);
      phase_on_next      = 1'b1;
      tick_count_next    = '0;
      attempt_count_next = '0;
    end

    result.drive_pins = phase_on ? pat : '0;
    result.step_index = step_reg_next;
    result.driving    = phase_on;
    result.advanced   = adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg      <= '0;
      phase_on      <= 1'b1;
      tick_count    <= '0;
      attempt_count <= '0;
    end else if (accept) begin
      step_reg      <= step_reg_next;
      phase_on      <= phase_on_next;
      tick_count    <= tick_count_next;
      attempt_count <= attempt_count_next;
    end
  end

endmodule

>>> rtl/six_step_commutation_sequencer.sv
// Top level of the sensed six-step commutation sequencer.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in       | in_valid / in_stall    | sense_pins
//   out      | out_valid / out_stall  | drive_pins, step_index, driving, advanced
//   cfg      | cfg_wr_en              | cfg_index, cfg_data
//
// One tick transaction is taken per clock while in_stall is low, and its result is
// registered in the result register, or in the skid register while a result waits.
// That rate is set by the state update in sscs_ctrl, done once per accepted transaction.
// A two-entry output buffer (result register plus skid register) lets the input
// keep flowing while one result waits; in_stall rises only when both are full.
// rst is synchronous: it restores register defaults, step 0, drive phase, counters 0.
module six_step_commutation_sequencer #(
  parameter int TIME_BITS = sscs_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sscs_pkg::PIN_W-1:0]        sense_pins,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sscs_pkg::PIN_W-1:0]        drive_pins,
  output logic [sscs_pkg::STEP_W-1:0]       step_index,
  output logic                              driving,
  output logic                              advanced,
  input  logic                              cfg_wr_en,
  input  logic [sscs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sscs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sscs_pkg::*;

  `include "six_step_commutation_sequencer_macros.svh"

  sscs_cfg_t    cfg;
  sscs_result_t new_result;
  sscs_result_t out_reg;
  sscs_result_t skid_reg;
  logic         skid_valid;
  logic         accept;
  logic         take;

  // Configuration registers: write-only, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_ticks     <= ON_TICKS_RST;
      cfg.off_ticks    <= OFF_TICKS_RST;
      cfg.max_attempts <= MAX_ATTEMPTS_RST;
      cfg.reverse_dir  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (sscs_reg_t'(cfg_index))
        REG_ON_TICKS:     cfg.on_ticks     <= cfg_data[ON_W-1:0];
        REG_OFF_TICKS:    cfg.off_ticks    <= cfg_data[OFF_W-1:0];
        REG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[ATT_W-1:0];
        REG_REVERSE_DIR:  cfg.reverse_dir  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  sscs_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sense_pins (sense_pins),
    .cfg        (cfg),
    .result     (new_result)
  );

  // Output register with skid stage: refill from skid first, then from the core.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_reg <= new_result;
      end else begin
        out_reg <= new_result;
      end
    end
  end

  assign drive_pins = out_reg.drive_pins;
  assign step_index = out_reg.step_index;
  assign driving    = out_reg.driving;
  assign advanced   = out_reg.advanced;

  // Skid entry only ever sits behind a full result register.
  `SSCS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // Off-window results never drive the phases.
  `SSCS_ASSERT_NOW(a_off_no_drive, clk, rst, out_valid && !driving, drive_pins == '0)
  // Step index stays within the six steps.
  `SSCS_ASSERT_NOW(a_step_range, clk, rst, out_valid, step_index < STEPS)
  // A transaction taken while the result waits lands in the skid register.
  `SSCS_ASSERT_NEXT(a_skid_fill, clk, rst, accept && out_valid && out_stall, skid_valid)

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the six-step commutation sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sscs_pkg::*;

  localparam int TIME_BITS   = TIME_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  // Drive pattern of each step; the sense pins must show the same pattern
  // to end the off window early. Row 0 is forward, row 1 the reverse table.
  localparam logic [PIN_W-1:0] STEP_PATTERN [2][6] = '{
    '{3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5},
    '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5}
  };

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [PIN_W-1:0]      sense_pins = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [PIN_W-1:0]      drive_pins;
  logic [STEP_W-1:0]     step_index;
  logic                  driving;
  logic                  advanced;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Idle rates in percent per cycle, set by each test.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A test posts a long receiver hold-off here; the stall process takes it.
  int hold_req       = 0;
  int hold_left      = 0;
  int mismatches     = 0;

  // Shadow of the registers and of the sequencer state.
  sscs_cfg_t             shadow_cfg;
  logic [STEP_W-1:0]     step_now;
  logic                  in_drive;
  logic [TIME_BITS-1:0]  tick_cnt;
  logic [ATT_W-1:0]      attempt_cnt;

  // Results still owed by the block, oldest first.
  sscs_result_t expected_ticks [$];

  six_step_commutation_sequencer #(
    .TIME_BITS(TIME_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sense_pins(sense_pins),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_pins(drive_pins),
    .step_index(step_index),
    .driving   (driving),
    .advanced  (advanced),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #1 clk = ~clk;

  // Give up if the run hangs; a hang always counts as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Pattern the current step drives and expects back on the sense pins.
  function automatic logic [PIN_W-1:0] current_pattern();
    return STEP_PATTERN[shadow_cfg.reverse_dir][step_now];
  endfunction

  // Advance the shadow sequencer by one tick and return what the block owes.
  function automatic sscs_result_t commutate_tick(input logic [PIN_W-1:0] sense);
    sscs_result_t     res;
    logic [PIN_W-1:0] pat;
    int unsigned      on_lim;
    int unsigned      off_lim;
    int unsigned      att_lim;
    logic             step_done;
    pat = current_pattern();
    // Zero in any limit register behaves as one; clip the drive time to the
    // largest count the tick counter holds.
    on_lim  = (shadow_cfg.on_ticks == 0) ? 1 : shadow_cfg.on_ticks;
    if (on_lim > 2**TIME_BITS - 1) on_lim = 2**TIME_BITS - 1;
    off_lim = (shadow_cfg.off_ticks == 0) ? 1 : shadow_cfg.off_ticks;
    att_lim = (shadow_cfg.max_attempts == 0) ? 1 : shadow_cfg.max_attempts;
    step_done      = 1'b0;
    res.driving    = in_drive;
    res.drive_pins = '0;
    if (in_drive) begin
      res.drive_pins = pat;
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= on_lim) begin
        in_drive = 1'b0;
        tick_cnt = '0;
      end
    end else if (sense == pat) begin
      // Feedback seen: end the off window at once.
      step_done = 1'b1;
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= off_lim) begin
        attempt_cnt = attempt_cnt + 1'b1;
        if (attempt_cnt >= att_lim) begin
          step_done = 1'b1;
        end else begin
          in_drive = 1'b1;
          tick_cnt = '0;
        end
      end
    end
    if (step_done) begin
      step_now    = (step_now == STEPS - 1) ? '0 : step_now + 1'b1;
      in_drive    = 1'b1;
      tick_cnt    = '0;
      attempt_cnt = '0;
    end
    res.step_index = step_now;
    res.advanced   = step_done;
    return res;
  endfunction

  // Mostly random sense pins; in the off window often the expected pattern,
  // so that steps advance on feedback as well as on the attempt limit.
  function automatic logic [PIN_W-1:0] pick_sense();
    if (!in_drive && $urandom_range(99) < 35) return current_pattern();
    return PIN_W'($urandom_range(7));
  endfunction

  // Offer one tick transaction, after a random idle gap, and record its
  // expected result once the block takes it. Valid stays high on return so
  // back-to-back transactions need no extra edge.
  task automatic send_tick(input logic [PIN_W-1:0] sense);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sense_pins <= sense;
    do @(posedge clk); while (in_stall);
    expected_ticks.push_back(commutate_tick(sense));
  endtask

  // Drop valid and wait until every owed result is back, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register while idle and mirror it, masked to its width.
  task automatic write_reg(input sscs_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ON_TICKS:     shadow_cfg.on_ticks     = data[ON_W-1:0];
      REG_OFF_TICKS:    shadow_cfg.off_ticks    = data[OFF_W-1:0];
      REG_MAX_ATTEMPTS: shadow_cfg.max_attempts = data[ATT_W-1:0];
      REG_REVERSE_DIR:  shadow_cfg.reverse_dir  = data[0];
      default: ;
    endcase
  endtask

  // Mostly short windows so steps turn over often; now and then a zero or
  // a long drive time.
  task automatic load_random_settings();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)
      write_reg(REG_ON_TICKS, '0);
    else if (pick < 14)
      write_reg(REG_ON_TICKS, CFG_DATA_W'($urandom_range(1023, 100)));
    else
      write_reg(REG_ON_TICKS, CFG_DATA_W'($urandom_range(12, 1)));
    write_reg(REG_OFF_TICKS, CFG_DATA_W'($urandom_range(10)));
    write_reg(REG_MAX_ATTEMPTS, CFG_DATA_W'($urandom_range(6)));
    write_reg(REG_REVERSE_DIR, CFG_DATA_W'($urandom_range(1)));
  endtask

  // Reset values: a long drive phase on step 0, sense ignored.
  task automatic test_defaults();
    send_tick(3'd0);
    send_tick(3'd7);
    send_tick(pick_sense());
  endtask

  // Zero limits act as one: one drive tick, one off tick, one attempt.
  // Sweep every sense value so both matches and forced advances show up.
  task automatic test_zero_registers();
    write_reg(REG_ON_TICKS, '0);
    write_reg(REG_OFF_TICKS, '0);
    write_reg(REG_MAX_ATTEMPTS, '0);
    for (int i = 0; i < 8; i++) send_tick(PIN_W'(i));
  endtask

  // Data wider than a register is cut to its width.
  task automatic test_masked_writes();
    write_reg(REG_OFF_TICKS, 10'h302);
    write_reg(REG_MAX_ATTEMPTS, 10'h302);
    write_reg(REG_REVERSE_DIR, 10'h3FE);
    repeat (5) send_tick(pick_sense());
  endtask

  // Reverse table: answer every off tick with the expected pattern.
  task automatic test_reverse_table();
    write_reg(REG_REVERSE_DIR, 10'd1);
    write_reg(REG_ON_TICKS, 10'd1);
    write_reg(REG_OFF_TICKS, 10'd1);
    write_reg(REG_MAX_ATTEMPTS, 10'd1);
    repeat (7) send_tick(current_pattern());
  endtask

  // Largest values of the on, off and attempt registers, including the longest drive time.
  task automatic test_extremes();
    write_reg(REG_ON_TICKS, 10'd1023);
    write_reg(REG_OFF_TICKS, 10'd255);
    write_reg(REG_MAX_ATTEMPTS, 10'd255);
    write_reg(REG_REVERSE_DIR, 10'd0);
    send_tick(3'd7);
    send_tick(3'd0);
  endtask

  // Random sense under random settings, through every idle mode.
  task automatic test_random_traffic();
    int idle_mode [4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{12, 12}};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_mode[m][0];
      recv_stall_pct = idle_mode[m][1];
      for (int s = 0; s < 2; s++) begin
        load_random_settings();
        repeat (150) send_tick(pick_sense());
      end
    end
  endtask

  // Hold the output off for a long stretch while ticks keep coming, so the
  // output buffer fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_ON_TICKS, 10'd2);
    write_reg(REG_OFF_TICKS, 10'd2);
    write_reg(REG_MAX_ATTEMPTS, 10'd2);
    hold_req = 300;
    repeat (40) send_tick(pick_sense());
  endtask

  // Receiver: serve a posted hold-off first, else stall at the current rate.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    sscs_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: result with none expected: drive_pins=%0d step_index=%0d %s",
                 $time, drive_pins, step_index,
                 $sformatf("driving=%0d advanced=%0d", driving, advanced));
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("drive_pins", want.drive_pins, drive_pins);
        check_field("step_index", want.step_index, step_index);
        check_field("driving", want.driving, driving);
        check_field("advanced", want.advanced, advanced);
      end
    end
  end

  initial begin
    shadow_cfg.on_ticks     = ON_TICKS_RST;
    shadow_cfg.off_ticks    = OFF_TICKS_RST;
    shadow_cfg.max_attempts = MAX_ATTEMPTS_RST;
    shadow_cfg.reverse_dir  = 1'b0;
    step_now    = '0;
    in_drive    = 1'b1;
    tick_cnt    = '0;
    attempt_cnt = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_zero_registers();
    test_masked_writes();
    test_reverse_table();
    test_extremes();
    test_random_traffic();
    test_backpressure();

    // Drain, then give late or extra results time to show up.
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
